### hdl/wsnc_pkg.sv
// Shared constants, types and helpers for the weekly schedule next-change block.
`timescale 1ns / 1ps

package wsnc_pkg;

	localparam int HOURS            = 24;
	localparam int DAYS             = 7;
	localparam int VALUE_BITS       = 8;
	localparam int ENTRIES          = HOURS * DAYS;
	localparam int IDX_W            = $clog2(ENTRIES);
	localparam int MINS_W           = 14;
	localparam int MINUTES_PER_HOUR = 60;
	localparam int MINUTE_LAST      = 59;

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	typedef logic [IDX_W-1:0]      idx_t;
	typedef logic [VALUE_BITS-1:0] val_t;
	typedef logic [MINS_W-1:0]     mins_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CUR,
		ST_CAPT,
		ST_SCAN,
		ST_DONE
	} state_t;

	// One result, as handed from the sequencer to the output register.
	typedef struct packed {
		val_t  mode;
		logic  is_rec;
		mins_t mins;
		logic  none;
	} res_t;

	function automatic logic in_range(input logic [4:0] h, input logic [2:0] d);
		in_range = (32'(h) < HOURS) && (32'(d) < DAYS);
	endfunction

	function automatic idx_t entry_idx(input logic [4:0] h, input logic [2:0] d);
		entry_idx = idx_t'(IDX_W'(d) * IDX_W'(HOURS) + IDX_W'(h));
	endfunction

	function automatic idx_t idx_next(input idx_t a);
		idx_next = (a == idx_t'(ENTRIES - 1)) ? '0 : idx_t'(a + 1'b1);
	endfunction

endpackage

### hdl/wsnc_table.sv
// Mode table: one-port-write, one-port-read synchronous RAM with per-entry valid bits.
`timescale 1ns / 1ps

module wsnc_table (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  wsnc_pkg::idx_t       wr_addr,
	input  wsnc_pkg::val_t       wr_data,
	input  logic                 rd_en,
	input  wsnc_pkg::idx_t       rd_addr,
	output wsnc_pkg::val_t       rd_data
);
	import wsnc_pkg::*;

	val_t mem [ENTRIES];
	logic [ENTRIES-1:0] vld_q;
	val_t rdata_q;
	logic rvld_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	// never-written entries read as zero (reset value of the table)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			rvld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rvld_q <= vld_q[rd_addr];
			end
		end
	end

	assign rd_data = rvld_q ? rdata_q : '0;

endmodule

### hdl/wsnc_seq.sv
// Request sequencer: decodes a request and walks the table for a query.
`timescale 1ns / 1ps

module wsnc_seq (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic                 cmd,
	input  logic [4:0]           hour,
	input  logic [2:0]           day,
	input  logic [5:0]           minute,
	input  wsnc_pkg::val_t       record_value,
	input  logic                 all_record,
	input  wsnc_pkg::val_t       rd_data,
	input  logic                 res_take,
	output logic                 idle,
	output logic                 rd_en,
	output wsnc_pkg::idx_t       rd_addr,
	output logic                 res_valid,
	output wsnc_pkg::res_t       res
);
	import wsnc_pkg::*;

	state_t state_q, state_d;
	idx_t   addr_q;
	idx_t   chk_q;
	val_t   cur_q;
	mins_t  mins_q;
	res_t   res_q;

	logic                 differ;
	logic                 last;
	logic [MINS_W:0]      mins_sum;
	mins_t                mins_inc;
	logic [5:0]           min_clamp;

	assign differ    = (rd_data != cur_q);
	assign last      = (chk_q == idx_t'(ENTRIES - 1));
	assign mins_sum  = {1'b0, mins_q} + (MINS_W + 1)'(MINUTES_PER_HOUR);
	assign mins_inc  = mins_sum[MINS_W] ? '1 : mins_sum[MINS_W-1:0];
	assign min_clamp = (32'(minute) > MINUTE_LAST) ? 6'(MINUTE_LAST) : minute;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		idle      = 1'b0;
		rd_en     = 1'b0;
		rd_addr   = addr_q;
		res_valid = 1'b0;
		case (state_q)
			ST_IDLE: begin
				idle = 1'b1;
				if (start) begin
					if (cmd == CMD_QUERY && in_range(hour, day)) begin
						state_d = ST_CUR;
					end else begin
						state_d = ST_DONE;
					end
				end
			end
			ST_CUR: begin
				rd_en   = 1'b1;
				state_d = ST_CAPT;
			end
			ST_CAPT: begin
				if (ENTRIES == 1) begin
					state_d = ST_DONE;
				end else begin
					rd_en   = 1'b1;
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (differ || last) begin
					state_d = ST_DONE;
				end else begin
					rd_en = 1'b1;
				end
			end
			ST_DONE: begin
				res_valid = 1'b1;
				if (res_take) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					res_q      <= '0;
					addr_q     <= entry_idx(hour, day);
					mins_q     <= mins_t'(MINUTES_PER_HOUR) - mins_t'(min_clamp);
					if (cmd == CMD_QUERY && !in_range(hour, day)) begin
						res_q.is_rec <= (record_value == '0);
					end
				end
			end
			ST_CUR: begin
				addr_q <= idx_next(addr_q);
			end
			ST_CAPT: begin
				cur_q        <= rd_data;
				res_q.mode   <= rd_data;
				res_q.is_rec <= (rd_data == record_value);
				addr_q       <= idx_next(addr_q);
				chk_q        <= idx_t'(1);
				if (ENTRIES == 1) begin
					res_q.none <= 1'b1;
					res_q.mins <= ((rd_data == record_value) && all_record) ?
						'0 : mins_t'(MINUTES_PER_HOUR);
				end
			end
			ST_SCAN: begin
				if (differ) begin
					res_q.mins <= mins_q;
				end else if (last) begin
					res_q.none <= 1'b1;
					res_q.mins <= (res_q.is_rec && all_record) ?
						'0 : mins_t'(MINUTES_PER_HOUR);
				end else begin
					mins_q <= mins_inc;
					chk_q  <= idx_t'(chk_q + 1'b1);
					addr_q <= idx_next(addr_q);
				end
			end
			default: begin
			end
		endcase
	end

	assign res = res_q;

endmodule

### hdl/weekly_schedule_next_change.sv
// Top level of the weekly schedule next-change finder.
//
//   channel  direction  handshake            payload
//   in       input      in_valid/in_ready    cmd, hour, day, minute, value
//   out      output     out_valid/out_ready  mode_now, is_record,
//                                            minutes_to_change, no_change_found
//   cfg      input      cfg_wr_en            cfg_wr_data (record value)
//
// A write request writes the table entry at the accepting edge and then returns
// a result. A query reads the table through the single read port, one read per
// cycle, the walk stopping at the first differing entry or after the last entry.
// An out-of-range query returns its result without reading the table.
// Reset clears the table valid bits at once, so no clearing pass is needed.
// One request is in flight at a time; the output register lets the next request
// be accepted while a result waits for out_ready.
`timescale 1ns / 1ps

module weekly_schedule_next_change (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        cmd,
	input  logic [4:0]  hour,
	input  logic [2:0]  day,
	input  logic [5:0]  minute,
	input  logic [7:0]  value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  mode_now,
	output logic        is_record,
	output logic [13:0] minutes_to_change,
	output logic        no_change_found,
	input  logic        cfg_wr_en,
	input  logic [7:0]  cfg_wr_data
);
	import wsnc_pkg::*;

	val_t   rec_q;        // record value register
	logic   all_rec_q;    // every write so far matched the record value
	logic   acc;
	logic   wr_en;
	logic   rd_en;
	idx_t   rd_addr;
	val_t   rd_data;
	logic   res_valid;
	logic   res_take;
	res_t   res;
	logic   out_valid_q;
	res_t   out_q;

	assign acc   = in_valid && in_ready;
	// writes outside the table are dropped and leave the flag alone
	assign wr_en = acc && (cmd == CMD_WRITE) && in_range(hour, day);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_q     <= val_t'(1);
			all_rec_q <= 1'b1;
		end else begin
			if (cfg_wr_en) begin
				rec_q <= cfg_wr_data;
			end
			if (wr_en && (value != rec_q)) begin
				all_rec_q <= 1'b0;
			end
		end
	end

	wsnc_table u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_addr (entry_idx(hour, day)),
		.wr_data (value),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	wsnc_seq u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (acc),
		.cmd          (cmd),
		.hour         (hour),
		.day          (day),
		.minute       (minute),
		.record_value (rec_q),
		.all_record   (all_rec_q),
		.rd_data      (rd_data),
		.res_take     (res_take),
		.idle         (in_ready),
		.rd_en        (rd_en),
		.rd_addr      (rd_addr),
		.res_valid    (res_valid),
		.res          (res)
	);

	// output register: loads when empty or being drained this cycle
	assign res_take = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_take) begin
			out_q <= res;
		end
	end

	assign out_valid         = out_valid_q;
	assign mode_now          = out_q.mode;
	assign is_record         = out_q.is_rec;
	assign minutes_to_change = out_q.mins;
	assign no_change_found   = out_q.none;

endmodule

### hdl/wsnc_checker.sv
// Port-level checks for the weekly schedule next-change finder, bound to the top.
`timescale 1ns / 1ps

module wsnc_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic        is_record,
	input  logic [13:0] minutes_to_change,
	input  logic        no_change_found
);
	import wsnc_pkg::*;

	// a waiting result stays until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped before it was taken");

	// one request at a time: no back-to-back acceptance
	a_one_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request accepted while another is in flight");

	// a full-week scan without change reports only continuous or one hour
	a_none_mins: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && no_change_found |->
			(minutes_to_change == '0 ||
			 minutes_to_change == 14'(MINUTES_PER_HOUR)))
		else $error("bad minute count for unchanged week");

	// continuous record mode requires the current value to be the record value
	a_cont_rec: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && no_change_found && minutes_to_change == '0 |-> is_record)
		else $error("continuous result without record mode");

endmodule

bind weekly_schedule_next_change wsnc_checker u_wsnc_checker (.*);
